// File: hw/rtl/sha256mh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256mh_pkg
// Shared types, constants and round functions of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha256mh_pkg;

    typedef logic [31:0] t_word;

    // Eight 32-bit words, word 0 in the lowest bits.
    typedef logic [7:0][31:0] t_hash;

    // Controls from the sequencer to the round unit.
    typedef struct packed {
        logic load_vars;
        logic do_round;
        logic add_chain;
        logic init_chain;
    } t_rnd_ctrl;

    localparam t_hash IV_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;

    localparam t_word K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rot_mix_a(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word rot_mix_e(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word sched_mix_w15(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word sched_mix_w2(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// File: hw/rtl/sha256mh_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256mh_sched
// Sixteen-word block window: gathers bytes big-endian, then shifts out one
// schedule word per round while appending the expanded word sixteen ahead.
// ----------------------------------------------------------------------------
module sha256mh_sched (
    input  logic               i_clk,
    input  logic               i_byte_en,
    input  logic [7:0]         i_byte,
    input  logic               i_word_en,
    output sha256mh_pkg::t_word o_w
);
    import sha256mh_pkg::*;

    // Word 15 is the oldest, i.e. the schedule word of the current round.
    logic [15:0][31:0] r_win;
    logic [511:0]      w_flat;
    t_word             w_next;

    assign w_flat = r_win;
    assign w_next = sched_mix_w2(r_win[1]) + r_win[6] + sched_mix_w15(r_win[14]) + r_win[15];
    assign o_w    = r_win[15];

    always_ff @(posedge i_clk) begin
        if (i_byte_en) begin
            r_win <= {w_flat[503:0], i_byte};
        end else if (i_word_en) begin
            r_win <= {w_flat[479:0], w_next};
        end
    end

endmodule

// File: hw/rtl/sha256mh_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256mh_round
// Compression round unit: working variables a to h, one round per cycle,
// and the chain value that the finished block is added into.
// ----------------------------------------------------------------------------
module sha256mh_round (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sha256mh_pkg::t_rnd_ctrl i_ctrl,
    input  sha256mh_pkg::t_word     i_w,
    input  sha256mh_pkg::t_word     i_k,
    output sha256mh_pkg::t_hash     o_chain
);
    import sha256mh_pkg::*;

    t_hash r_chain;
    t_hash r_vars;
    t_word w_t1;
    t_word w_t2;
    t_word w_ch;
    t_word w_maj;

    assign w_ch  = (r_vars[4] & r_vars[5]) ^ (~r_vars[4] & r_vars[6]);
    assign w_maj = (r_vars[0] & r_vars[1]) ^ (r_vars[0] & r_vars[2]) ^ (r_vars[1] & r_vars[2]);
    assign w_t1  = r_vars[7] + rot_mix_e(r_vars[4]) + w_ch + i_k + i_w;
    assign w_t2  = rot_mix_a(r_vars[0]) + w_maj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= IV_HASH;
        end else if (i_ctrl.init_chain) begin
            r_chain <= IV_HASH;
        end else if (i_ctrl.add_chain) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + r_vars[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_vars) begin
            r_vars <= r_chain;
        end else if (i_ctrl.do_round) begin
            r_vars[7] <= r_vars[6];
            r_vars[6] <= r_vars[5];
            r_vars[5] <= r_vars[4];
            r_vars[4] <= r_vars[3] + w_t1;
            r_vars[3] <= r_vars[2];
            r_vars[2] <= r_vars[1];
            r_vars[1] <= r_vars[0];
            r_vars[0] <= w_t1 + w_t2;
        end
    end

    assign o_chain = r_chain;

endmodule

// File: hw/rtl/sha256_message_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_hash
// Streaming SHA-256 of a byte message: one byte per request, digest out on
// the request that ends the message.
// ----------------------------------------------------------------------------
//  Port group   Dir  Payload
//  s_axis_*     in   tdata: data_byte; tuser: byte_present; tlast: last
//  m_axis_*     out  tdata: digest_word_0 .. digest_word_7
//
//  The byte that completes a 64-byte block starts the rounds, then the chain
//  add, on the single round unit. The input is held off while busy. The last
//  request inserts padding and length one byte per cycle between compressions,
//  runs one or two compressions, then loads the digest register. Reset loads
//  the initial hash. A waiting digest holds the input off only once the next
//  message has been finished.
// ----------------------------------------------------------------------------
module sha256_message_hash (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_axis_tuser,   // [0] byte_present
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata    // digest_word_0 [31:0] .. digest_word_7 [255:224]
);
    import sha256mh_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_count, n_count;
    logic [5:0]  r_rnd, n_rnd;
    logic        r_pad_act, n_pad_act;
    logic        r_first, n_first;
    logic        r_len, n_len;
    logic        r_final, n_final;
    logic        r_m_valid, n_m_valid;
    t_hash       r_digest;

    logic        w_s_acc;
    logic        w_byte_en;
    logic [7:0]  w_byte;
    logic        w_is_len;
    logic        w_load_out;
    t_word       w_w;
    t_hash       w_chain;
    t_rnd_ctrl   w_ctrl;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;

    // The length field starts once zero fill has reached byte 56 of a block.
    assign w_is_len   = r_len || (!r_first && (r_pos == LEN_START));
    assign w_load_out = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    always_comb begin
        w_byte_en = 1'b0;
        w_byte    = s_axis_tdata;
        case (r_state)
            S_IDLE: begin
                w_byte_en = w_s_acc && s_axis_tuser[0];
            end
            S_PAD: begin
                w_byte_en = 1'b1;
                if (r_first) begin
                    w_byte = PAD_MARK;
                end else if (w_is_len) begin
                    w_byte = r_count[63:56];
                end else begin
                    w_byte = 8'h00;
                end
            end
            default: begin
                w_byte_en = 1'b0;
            end
        endcase
    end

    assign w_ctrl.load_vars  = w_byte_en && (r_pos == BLOCK_LAST);
    assign w_ctrl.do_round   = (r_state == S_ROUND);
    assign w_ctrl.add_chain  = (r_state == S_ADD);
    assign w_ctrl.init_chain = w_load_out;

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_count   = r_count;
        n_rnd     = r_rnd;
        n_pad_act = r_pad_act;
        n_first   = r_first;
        n_len     = r_len;
        n_final   = r_final;
        n_m_valid = r_m_valid && !m_axis_tready;
        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    if (s_axis_tuser[0]) begin
                        n_count = r_count + 64'd8;
                        n_pos   = r_pos + 6'd1;
                    end
                    if (s_axis_tlast) begin
                        n_pad_act = 1'b1;
                        n_first   = 1'b1;
                    end
                    if (w_byte_en && (r_pos == BLOCK_LAST)) begin
                        n_state = S_ROUND;
                        n_rnd   = '0;
                    end else if (s_axis_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_pos   = r_pos + 6'd1;
                n_first = 1'b0;
                n_len   = w_is_len;
                if (w_is_len && !r_first) begin
                    n_count = {r_count[55:0], 8'h00};
                end
                if (r_pos == BLOCK_LAST) begin
                    n_state = S_ROUND;
                    n_rnd   = '0;
                    n_final = w_is_len && !r_first;
                end
            end
            S_ROUND: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == BLOCK_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_final) begin
                    n_state = S_DONE;
                end else if (r_pad_act) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_m_valid = 1'b1;
                    n_pad_act = 1'b0;
                    n_first   = 1'b0;
                    n_len     = 1'b0;
                    n_final   = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_count   <= '0;
            r_rnd     <= '0;
            r_pad_act <= 1'b0;
            r_first   <= 1'b0;
            r_len     <= 1'b0;
            r_final   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_rnd     <= n_rnd;
            r_pad_act <= n_pad_act;
            r_first   <= n_first;
            r_len     <= n_len;
            r_final   <= n_final;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_digest <= w_chain;
        end
    end

    sha256mh_sched u_sched (
        .i_clk     (i_clk),
        .i_byte_en (w_byte_en),
        .i_byte    (w_byte),
        .i_word_en (w_ctrl.do_round),
        .o_w       (w_w)
    );

    sha256mh_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_w     (w_w),
        .i_k     (K_TABLE[r_rnd]),
        .o_chain (w_chain)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_digest;

endmodule

// File: hw/rtl/sha256mh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256mh_checker
// Port-level checks of the SHA-256 message hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha256mh_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [255:0] m_axis_tdata
);

    // Reset clears the digest valid.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("digest valid after reset");

    // A waiting digest is held unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest changed while stalled");

    // The end of a message always sends the block into padding or compression.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("ready straight after the last request");

    // A new digest only appears after the block has been busy finishing it.
    a_digest_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("digest appeared while the input was idle");

endmodule

bind sha256_message_hash sha256mh_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
